// ===== design/ermg_pkg.sv =====
// ---------------------------------------------------------------------------
// ermg_pkg
// Shared types, codes and constants of the rotation matrix generator.
// ---------------------------------------------------------------------------
package ermg_pkg;

    localparam int OP_W      = 3;
    localparam int ANG_W     = 32;
    localparam int SHIFT_W   = 48;
    localparam int SCALE_W   = 32;
    localparam int ENTRY_W   = 48;
    localparam int THR_W     = 10;
    localparam int TRIG_W    = 34;
    localparam int REM_W     = 32;
    localparam int DIV_STEPS = 48;

    localparam logic [OP_W-1:0] OP_DIRECT  = 3'd0;
    localparam logic [OP_W-1:0] OP_D_OMEGA = 3'd1;
    localparam logic [OP_W-1:0] OP_D_PHI   = 3'd2;
    localparam logic [OP_W-1:0] OP_D_KAPPA = 3'd3;
    localparam logic [OP_W-1:0] OP_D_TX    = 3'd4;
    localparam logic [OP_W-1:0] OP_D_TY    = 3'd5;
    localparam logic [OP_W-1:0] OP_D_TZ    = 3'd6;
    localparam logic [OP_W-1:0] OP_D_SCALE = 3'd7;

    localparam logic [THR_W-1:0] THR_RESET = 10'd4;

    typedef logic signed [TRIG_W-1:0]  t_trig;
    typedef logic signed [ENTRY_W-1:0] t_entry;
    typedef t_entry [3:0] t_row;
    typedef t_row   [3:0] t_mat;

    localparam t_trig  HALF_PI = 34'sd1686629713;
    localparam t_trig  PI_Q30  = 34'sd3373259426;
    localparam t_trig  GAIN    = 34'sd652032874;
    localparam t_entry ONE_Q30 = 48'sd1073741824;
    localparam t_entry MAX48   = 48'sh7FFF_FFFF_FFFF;
    localparam t_entry MIN48   = 48'sh8000_0000_0000;

    typedef struct packed {
        t_trig oc;
        t_trig os;
        t_trig pc;
        t_trig ps;
        t_trig kc;
        t_trig ks;
    } t_trig_set;

    typedef struct packed {
        t_entry tx;
        t_entry ty;
        t_entry tz;
        t_entry inv;
    } t_div_set;

    typedef struct packed {
        logic            valid;
        logic [OP_W-1:0] op;
        logic            err;
    } t_side;

    function automatic t_trig atan_step(input int i);
        t_trig v;
        case (i)
            0:       v = 34'sd843314857;
            1:       v = 34'sd497837829;
            2:       v = 34'sd263043837;
            3:       v = 34'sd133525159;
            4:       v = 34'sd67021687;
            5:       v = 34'sd33543516;
            6:       v = 34'sd16775851;
            7:       v = 34'sd8388437;
            8:       v = 34'sd4194283;
            9:       v = 34'sd2097149;
            10:      v = 34'sd1048576;
            default: v = (i <= 30) ? (t_trig'(1) <<< (30 - i)) : t_trig'(0);
        endcase
        return v;
    endfunction

    // Q4.30 product, rounded half up
    function automatic t_trig mulq(input t_trig a, input t_trig b);
        logic signed [2*TRIG_W-1:0] ea;
        logic signed [2*TRIG_W-1:0] eb;
        logic signed [2*TRIG_W-1:0] p;
        ea = a;
        eb = b;
        p  = ea * eb + (2*TRIG_W)'(64'sd536870912);
        return t_trig'(p >>> 30);
    endfunction

endpackage

// ===== design/euler_rotation_matrix_generator.sv =====
// ---------------------------------------------------------------------------
// euler_rotation_matrix_generator
// Omega-phi-kappa homogeneous matrix and derivative generator.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction per
//   matrix: operation, three angles, three translations and a scale.
//   Output channel (o_out_valid / i_out_stall) returns four row
//   transactions per matrix, row 0 first, last_row on row 3. A zero or
//   below-threshold scale gives a single all-zero row with scale_error.
//   The threshold register is written through i_cfg_valid / o_cfg_ready
//   (always ready); write it only while the block is idle.
// Pipeline: from an accepted input to its first row lie a fold stage,
//   48 divider stages (the CORDIC runs alongside, one iteration a stage),
//   a rounding stage, three product/select stages and the output register.
// Throughput: set by the output register, which hands out one row per cycle
//   while not stalled; input transactions may arrive back to back and the
//   pipeline holds them until the output register frees.
// Stall: a stalled output row holds; the whole pipeline freezes when the
//   output register is full and its head carries a valid matrix.
// Reset: clears every valid bit and sets the threshold to 4.
//   CORDIC_STEPS may range from 16 to 40.
// ---------------------------------------------------------------------------
module euler_rotation_matrix_generator import ermg_pkg::*; #(
    parameter int CORDIC_STEPS = 30
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [OP_W-1:0]           i_operation,
    input  logic signed [ANG_W-1:0]   i_omega_angle,
    input  logic signed [ANG_W-1:0]   i_phi_angle,
    input  logic signed [ANG_W-1:0]   i_kappa_angle,
    input  logic signed [SHIFT_W-1:0] i_shift_x,
    input  logic signed [SHIFT_W-1:0] i_shift_y,
    input  logic signed [SHIFT_W-1:0] i_shift_z,
    input  logic [SCALE_W-1:0]        i_scale_factor,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [THR_W-1:0]          i_cfg_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_row_index,
    output logic signed [ENTRY_W-1:0] o_entry_0,
    output logic signed [ENTRY_W-1:0] o_entry_1,
    output logic signed [ENTRY_W-1:0] o_entry_2,
    output logic signed [ENTRY_W-1:0] o_entry_3,
    output logic                      o_last_row,
    output logic                      o_scale_error
);

    logic [THR_W-1:0] r_thr;
    logic             w_en;
    logic             w_load;
    t_side            w_in_side;
    t_trig_set        w_trig;
    t_side            w_cor_side;
    t_div_set         w_div;
    t_mat             w_mat;
    t_side            w_mat_side;

    // threshold register; the port never pushes back
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    // advance the pipeline unless the output register is full and a
    // finished matrix waits behind it
    assign w_en       = w_load || !w_mat_side.valid;
    assign o_in_stall = !w_en;

    // flag a zero or below-threshold scale at the door; it travels with the transaction
    assign w_in_side.valid = i_in_valid;
    assign w_in_side.op    = i_operation;
    assign w_in_side.err   = (i_scale_factor == '0)
                          || (i_scale_factor < SCALE_W'(r_thr));

    ermg_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (w_in_side),
        .i_omega (i_omega_angle),
        .i_phi   (i_phi_angle),
        .i_kappa (i_kappa_angle),
        .i_thr   (r_thr),
        .o_trig  (w_trig),
        .o_side  (w_cor_side)
    );

    ermg_div u_div (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_shift_x (i_shift_x),
        .i_shift_y (i_shift_y),
        .i_shift_z (i_shift_z),
        .i_scale   (i_scale_factor),
        .o_div     (w_div)
    );

    ermg_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_trig  (w_trig),
        .i_div   (w_div),
        .i_side  (w_cor_side),
        .o_mat   (w_mat),
        .o_side  (w_mat_side)
    );

    ermg_rows u_rows (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mat         (w_mat),
        .i_side        (w_mat_side),
        .i_out_stall   (i_out_stall),
        .o_load        (w_load),
        .o_out_valid   (o_out_valid),
        .o_row_index   (o_row_index),
        .o_entry_0     (o_entry_0),
        .o_entry_1     (o_entry_1),
        .o_entry_2     (o_entry_2),
        .o_entry_3     (o_entry_3),
        .o_last_row    (o_last_row),
        .o_scale_error (o_scale_error)
    );

endmodule

// ===== design/ermg_cordic.sv =====
// ---------------------------------------------------------------------------
// ermg_cordic
// Three pipelined rotation-mode CORDIC lanes, one iteration per stage for the first STEPS stages.
// ---------------------------------------------------------------------------
module ermg_cordic import ermg_pkg::*; #(
    parameter int STEPS = 30
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  t_side                   i_side,
    input  logic signed [ANG_W-1:0] i_omega,
    input  logic signed [ANG_W-1:0] i_phi,
    input  logic signed [ANG_W-1:0] i_kappa,
    input  logic [THR_W-1:0]        i_thr,
    output t_trig_set               o_trig,
    output t_side                   o_side
);

    localparam int NST = DIV_STEPS;

    t_trig r_x   [0:NST][0:2];
    t_trig r_y   [0:NST][0:2];
    t_trig r_z   [0:NST][0:2];
    logic  r_neg [0:NST][0:2];
    t_side r_sd  [0:NST];

    t_trig n_z   [0:2];
    logic  n_neg [0:2];
    t_trig w_ang [0:2];

    t_trig r_c [0:2];
    t_trig r_s [0:2];
    t_side r_sd_out;

    assign w_ang[0] = t_trig'(i_omega) <<< 1;
    assign w_ang[1] = t_trig'(i_phi) <<< 1;
    assign w_ang[2] = t_trig'(i_kappa) <<< 1;

    // fold the angle into [-pi/2, pi/2]
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_z[a]   = w_ang[a];
            n_neg[a] = 1'b0;
            if (w_ang[a] > HALF_PI) begin
                n_z[a]   = w_ang[a] - PI_Q30;
                n_neg[a] = 1'b1;
            end else if (w_ang[a] < -HALF_PI) begin
                n_z[a]   = w_ang[a] + PI_Q30;
                n_neg[a] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd[0].valid <= 1'b0;
        end else if (i_en) begin
            r_sd[0].valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0].op  <= i_side.op;
            r_sd[0].err <= i_side.err;
            for (int a = 0; a < 3; a++) begin
                r_x[0][a]   <= GAIN;
                r_y[0][a]   <= '0;
                r_z[0][a]   <= n_z[a];
                r_neg[0][a] <= n_neg[a];
            end
        end
    end

    for (genvar k = 1; k <= NST; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sd[k].valid <= 1'b0;
            end else if (i_en) begin
                r_sd[k].valid <= r_sd[k-1].valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sd[k].op  <= r_sd[k-1].op;
                r_sd[k].err <= r_sd[k-1].err;
                for (int a = 0; a < 3; a++) begin
                    r_neg[k][a] <= r_neg[k-1][a];
                    if (k - 1 < STEPS) begin
                        if (r_z[k-1][a] >= 0) begin
                            r_x[k][a] <= r_x[k-1][a] - (r_y[k-1][a] >>> (k - 1));
                            r_y[k][a] <= r_y[k-1][a] + (r_x[k-1][a] >>> (k - 1));
                            r_z[k][a] <= r_z[k-1][a] - atan_step(k - 1);
                        end else begin
                            r_x[k][a] <= r_x[k-1][a] + (r_y[k-1][a] >>> (k - 1));
                            r_y[k][a] <= r_y[k-1][a] - (r_x[k-1][a] >>> (k - 1));
                            r_z[k][a] <= r_z[k-1][a] + atan_step(k - 1);
                        end
                    end else begin
                        r_x[k][a] <= r_x[k-1][a];
                        r_y[k][a] <= r_y[k-1][a];
                        r_z[k][a] <= r_z[k-1][a];
                    end
                end
            end
        end
    end

    // restore the sign of the fold, then drop tiny magnitudes to zero
    t_trig w_cx [0:2];
    t_trig w_sy [0:2];
    t_trig w_cm [0:2];
    t_trig w_sm [0:2];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_cx[a] = r_neg[NST][a] ? -r_x[NST][a] : r_x[NST][a];
            w_sy[a] = r_neg[NST][a] ? -r_y[NST][a] : r_y[NST][a];
            w_cm[a] = (w_cx[a] < 0) ? -w_cx[a] : w_cx[a];
            w_sm[a] = (w_sy[a] < 0) ? -w_sy[a] : w_sy[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd_out.valid <= 1'b0;
        end else if (i_en) begin
            r_sd_out.valid <= r_sd[NST].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd_out.op  <= r_sd[NST].op;
            r_sd_out.err <= r_sd[NST].err;
            for (int a = 0; a < 3; a++) begin
                r_c[a] <= ($unsigned(w_cm[a]) < TRIG_W'(i_thr)) ? t_trig'(0) : w_cx[a];
                r_s[a] <= ($unsigned(w_sm[a]) < TRIG_W'(i_thr)) ? t_trig'(0) : w_sy[a];
            end
        end
    end

    assign o_trig.oc = r_c[0];
    assign o_trig.os = r_s[0];
    assign o_trig.pc = r_c[1];
    assign o_trig.ps = r_s[1];
    assign o_trig.kc = r_c[2];
    assign o_trig.ks = r_s[2];
    assign o_side    = r_sd_out;

endmodule

// ===== design/ermg_div.sv =====
// ---------------------------------------------------------------------------
// ermg_div
// Four pipelined restoring dividers: translation over scale and 1/scale.
// ---------------------------------------------------------------------------
module ermg_div import ermg_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [SHIFT_W-1:0] i_shift_x,
    input  logic signed [SHIFT_W-1:0] i_shift_y,
    input  logic signed [SHIFT_W-1:0] i_shift_z,
    input  logic [SCALE_W-1:0]        i_scale,
    output t_div_set                  o_div
);

    localparam int NST = DIV_STEPS;

    logic [REM_W-1:0]   r_rem [0:NST][0:3];
    logic [NST-1:0]     r_q   [0:NST][0:3];
    logic [NST-1:0]     r_num [0:NST][0:3];
    logic               r_neg [0:NST][0:3];
    logic               r_sat [0:NST][0:3];
    logic [SCALE_W-1:0] r_s   [0:NST];

    logic signed [SHIFT_W-1:0] w_t   [0:2];
    logic [SHIFT_W-1:0]        w_mag [0:2];
    logic                      w_neg [0:2];

    assign w_t[0] = i_shift_x;
    assign w_t[1] = i_shift_y;
    assign w_t[2] = i_shift_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_neg[a] = w_t[a] < 0;
            w_mag[a] = w_neg[a] ? $unsigned(-w_t[a]) : $unsigned(w_t[a]);
        end
    end

    // quotient bits above bit 47 are zero unless the result saturates
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s[0] <= i_scale;
            for (int a = 0; a < 3; a++) begin
                r_neg[0][a] <= w_neg[a];
                r_sat[0][a] <= {2'b00, w_mag[a]} >= {i_scale, 18'd0};
                r_rem[0][a] <= REM_W'(w_mag[a] >> 18);
                r_num[0][a] <= {w_mag[a][17:0], 30'd0};
                r_q[0][a]   <= '0;
            end
            // 2^60 as a remainder of 4096 followed by zero bits; the final
            // half-up step does the rounding
            r_neg[0][3] <= 1'b0;
            r_sat[0][3] <= i_scale <= SCALE_W'(8192);
            r_rem[0][3] <= REM_W'(4096);
            r_num[0][3] <= '0;
            r_q[0][3]   <= '0;
        end
    end

    for (genvar k = 1; k <= NST; k++) begin : g_stage
        logic [REM_W:0] w_try [0:3];
        logic           w_ge  [0:3];

        always_comb begin
            for (int a = 0; a < 4; a++) begin
                w_try[a] = {r_rem[k-1][a], r_num[k-1][a][NST-k]};
                w_ge[a]  = w_try[a] >= {1'b0, r_s[k-1]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[k] <= r_s[k-1];
                for (int a = 0; a < 4; a++) begin
                    r_neg[k][a] <= r_neg[k-1][a];
                    r_sat[k][a] <= r_sat[k-1][a];
                    r_num[k][a] <= r_num[k-1][a];
                    r_q[k][a]   <= {r_q[k-1][a][NST-2:0], w_ge[a]};
                    r_rem[k][a] <= w_ge[a] ? REM_W'(w_try[a] - {1'b0, r_s[k-1]})
                                           : w_try[a][REM_W-1:0];
                end
            end
        end
    end

    logic [NST:0] w_qr  [0:3];
    t_entry       w_res [0:3];
    t_entry       r_res [0:3];

    always_comb begin
        for (int a = 0; a < 4; a++) begin
            w_qr[a] = {1'b0, r_q[NST][a]}
                    + (NST+1)'({r_rem[NST][a], 1'b0} >= {1'b0, r_s[NST]});
            if (r_sat[NST][a]) begin
                w_res[a] = r_neg[NST][a] ? MIN48 : MAX48;
            end else if (!r_neg[NST][a]) begin
                w_res[a] = (w_qr[a] > (NST+1)'(MAX48)) ? MAX48 : t_entry'(w_qr[a][NST-1:0]);
            end else begin
                w_res[a] = (w_qr[a] > {2'b01, {(NST-1){1'b0}}}) ? MIN48
                         : -t_entry'(w_qr[a][NST-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 4; a++) begin
                r_res[a] <= w_res[a];
            end
        end
    end

    assign o_div.tx  = r_res[0];
    assign o_div.ty  = r_res[1];
    assign o_div.tz  = r_res[2];
    assign o_div.inv = r_res[3];

endmodule

// ===== design/ermg_matrix.sv =====
// ---------------------------------------------------------------------------
// ermg_matrix
// Pair products, triple products, then entry selection by operation.
// ---------------------------------------------------------------------------
module ermg_matrix import ermg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_trig_set i_trig,
    input  t_div_set  i_div,
    input  t_side     i_side,
    output t_mat      o_mat,
    output t_side     o_side
);

    // stage A
    t_side     r_sd_a;
    t_trig_set r_tr_a;
    t_div_set  r_dv_a;
    t_trig r_kcpc, r_kspc, r_kcps, r_ksps, r_ksoc, r_kcoc;
    t_trig r_pcos, r_pcoc, r_ksos, r_kcos, r_psos, r_psoc;

    // stage B
    t_side    r_sd_b;
    t_div_set r_dv_b;
    t_trig r_pc_b, r_ps_b;
    t_trig r_kcpc_b, r_kspc_b, r_kcps_b, r_ksps_b, r_ksoc_b, r_kcoc_b;
    t_trig r_pcos_b, r_pcoc_b, r_ksos_b, r_kcos_b, r_psos_b, r_psoc_b;
    t_trig r_kcps_os, r_kcps_oc, r_ksps_os, r_ksps_oc;
    t_trig r_kcpc_os, r_kcpc_oc, r_kspc_os, r_kspc_oc;

    // stage C
    t_side r_sd_c;
    t_mat  r_mat;
    t_mat  n_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd_a.valid <= 1'b0;
            r_sd_b.valid <= 1'b0;
            r_sd_c.valid <= 1'b0;
        end else if (i_en) begin
            r_sd_a.valid <= i_side.valid;
            r_sd_b.valid <= r_sd_a.valid;
            r_sd_c.valid <= r_sd_b.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd_a.op  <= i_side.op;
            r_sd_a.err <= i_side.err;
            r_tr_a     <= i_trig;
            r_dv_a     <= i_div;
            r_kcpc     <= mulq(i_trig.kc, i_trig.pc);
            r_kspc     <= mulq(i_trig.ks, i_trig.pc);
            r_kcps     <= mulq(i_trig.kc, i_trig.ps);
            r_ksps     <= mulq(i_trig.ks, i_trig.ps);
            r_ksoc     <= mulq(i_trig.ks, i_trig.oc);
            r_kcoc     <= mulq(i_trig.kc, i_trig.oc);
            r_pcos     <= mulq(i_trig.pc, i_trig.os);
            r_pcoc     <= mulq(i_trig.pc, i_trig.oc);
            r_ksos     <= mulq(i_trig.ks, i_trig.os);
            r_kcos     <= mulq(i_trig.kc, i_trig.os);
            r_psos     <= mulq(i_trig.ps, i_trig.os);
            r_psoc     <= mulq(i_trig.ps, i_trig.oc);

            r_sd_b.op  <= r_sd_a.op;
            r_sd_b.err <= r_sd_a.err;
            r_dv_b     <= r_dv_a;
            r_pc_b     <= r_tr_a.pc;
            r_ps_b     <= r_tr_a.ps;
            r_kcpc_b   <= r_kcpc;
            r_kspc_b   <= r_kspc;
            r_kcps_b   <= r_kcps;
            r_ksps_b   <= r_ksps;
            r_ksoc_b   <= r_ksoc;
            r_kcoc_b   <= r_kcoc;
            r_pcos_b   <= r_pcos;
            r_pcoc_b   <= r_pcoc;
            r_ksos_b   <= r_ksos;
            r_kcos_b   <= r_kcos;
            r_psos_b   <= r_psos;
            r_psoc_b   <= r_psoc;
            r_kcps_os  <= mulq(r_kcps, r_tr_a.os);
            r_kcps_oc  <= mulq(r_kcps, r_tr_a.oc);
            r_ksps_os  <= mulq(r_ksps, r_tr_a.os);
            r_ksps_oc  <= mulq(r_ksps, r_tr_a.oc);
            r_kcpc_os  <= mulq(r_kcpc, r_tr_a.os);
            r_kcpc_oc  <= mulq(r_kcpc, r_tr_a.oc);
            r_kspc_os  <= mulq(r_kspc, r_tr_a.os);
            r_kspc_oc  <= mulq(r_kspc, r_tr_a.oc);

            r_sd_c.op  <= r_sd_b.op;
            r_sd_c.err <= r_sd_b.err;
            r_mat      <= n_mat;
        end
    end

    always_comb begin
        n_mat = '0;
        case (r_sd_b.op)
            OP_DIRECT, OP_D_SCALE: begin
                n_mat[0][0] = t_entry'(r_kcpc_b);
                n_mat[0][1] = t_entry'(r_kspc_b);
                n_mat[0][2] = t_entry'(-r_ps_b);
                n_mat[1][0] = t_entry'(r_kcps_os - r_ksoc_b);
                n_mat[1][1] = t_entry'(r_ksps_os + r_kcoc_b);
                n_mat[1][2] = t_entry'(r_pcos_b);
                n_mat[2][0] = t_entry'(r_kcps_oc + r_ksos_b);
                n_mat[2][1] = t_entry'(r_ksps_oc - r_kcos_b);
                n_mat[2][2] = t_entry'(r_pcoc_b);
                if (r_sd_b.op == OP_DIRECT) begin
                    n_mat[0][3] = r_dv_b.tx;
                    n_mat[1][3] = r_dv_b.ty;
                    n_mat[2][3] = r_dv_b.tz;
                    n_mat[3][3] = r_dv_b.inv;
                end else begin
                    n_mat[3][3] = ONE_Q30;
                end
            end
            OP_D_OMEGA: begin
                n_mat[1][0] = t_entry'(r_kcps_oc + r_ksos_b);
                n_mat[1][1] = t_entry'(r_ksps_oc - r_kcos_b);
                n_mat[1][2] = t_entry'(r_pcoc_b);
                n_mat[2][0] = t_entry'(r_ksoc_b - r_kcps_os);
                n_mat[2][1] = t_entry'(-r_ksps_os - r_kcoc_b);
                n_mat[2][2] = t_entry'(-r_pcos_b);
                n_mat[3][3] = r_dv_b.inv;
            end
            OP_D_PHI: begin
                n_mat[0][0] = t_entry'(-r_kcps_b);
                n_mat[0][1] = t_entry'(-r_ksps_b);
                n_mat[0][2] = t_entry'(-r_pc_b);
                n_mat[1][0] = t_entry'(r_kcpc_os);
                n_mat[1][1] = t_entry'(r_kspc_os);
                n_mat[1][2] = t_entry'(-r_psos_b);
                n_mat[2][0] = t_entry'(r_kcpc_oc);
                n_mat[2][1] = t_entry'(r_kspc_oc);
                n_mat[2][2] = t_entry'(-r_psoc_b);
                n_mat[3][3] = r_dv_b.inv;
            end
            OP_D_KAPPA: begin
                n_mat[0][0] = t_entry'(-r_kspc_b);
                n_mat[0][1] = t_entry'(r_kcpc_b);
                n_mat[1][0] = t_entry'(-r_ksps_os - r_kcoc_b);
                n_mat[1][1] = t_entry'(r_kcps_os - r_ksoc_b);
                n_mat[2][0] = t_entry'(r_kcos_b - r_ksps_oc);
                n_mat[2][1] = t_entry'(r_kcps_oc + r_ksos_b);
                n_mat[3][3] = r_dv_b.inv;
            end
            OP_D_TX: begin
                n_mat[0][3] = ONE_Q30;
                n_mat[3][3] = ONE_Q30;
            end
            OP_D_TY: begin
                n_mat[1][3] = ONE_Q30;
                n_mat[3][3] = ONE_Q30;
            end
            OP_D_TZ: begin
                n_mat[2][3] = ONE_Q30;
                n_mat[3][3] = ONE_Q30;
            end
            default: begin
                n_mat = '0;
            end
        endcase
        if (r_sd_b.err) begin
            n_mat = '0;
        end
    end

    assign o_mat  = r_mat;
    assign o_side = r_sd_c;

endmodule

// ===== design/ermg_rows.sv =====
// ---------------------------------------------------------------------------
// ermg_rows
// Output register: holds one matrix and hands it out row by row.
// ---------------------------------------------------------------------------
module ermg_rows import ermg_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_mat         i_mat,
    input  t_side        i_side,
    input  logic         i_out_stall,
    output logic         o_load,
    output logic         o_out_valid,
    output logic [1:0]   o_row_index,
    output t_entry       o_entry_0,
    output t_entry       o_entry_1,
    output t_entry       o_entry_2,
    output t_entry       o_entry_3,
    output logic         o_last_row,
    output logic         o_scale_error
);

    logic       r_busy;
    logic [1:0] r_row;
    t_mat       r_mat;
    logic       r_err;
    logic       w_last;

    assign w_last = r_err || (r_row == 2'd3);
    assign o_load = !r_busy || (!i_out_stall && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
        end else if (o_load) begin
            r_busy <= i_side.valid;
            r_row  <= '0;
        end else if (!i_out_stall) begin
            r_row  <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load && i_side.valid) begin
            r_mat <= i_mat;
            r_err <= i_side.err;
        end
    end

    assign o_out_valid   = r_busy;
    assign o_row_index   = r_row;
    assign o_entry_0     = r_mat[r_row][0];
    assign o_entry_1     = r_mat[r_row][1];
    assign o_entry_2     = r_mat[r_row][2];
    assign o_entry_3     = r_mat[r_row][3];
    assign o_last_row    = w_last;
    assign o_scale_error = r_err;

endmodule

// ===== design/ermg_checker.sv =====
// ---------------------------------------------------------------------------
// ermg_props
// Port-level checks on the row stream of the matrix generator.
// ---------------------------------------------------------------------------
module ermg_props import ermg_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [1:0]                o_row_index,
    input logic signed [ENTRY_W-1:0] o_entry_0,
    input logic signed [ENTRY_W-1:0] o_entry_1,
    input logic signed [ENTRY_W-1:0] o_entry_2,
    input logic signed [ENTRY_W-1:0] o_entry_3,
    input logic                      o_last_row,
    input logic                      o_scale_error
);

    a_hold_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_err_row : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scale_error |-> o_last_row && (o_row_index == 2'd0)
            && (o_entry_0 == '0) && (o_entry_1 == '0)
            && (o_entry_2 == '0) && (o_entry_3 == '0))
        else $error("scale error row is not a single zero row");

    a_row_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_row |=>
            o_out_valid && (o_row_index == 2'($past(o_row_index) + 2'd1)))
        else $error("matrix rows not consecutive");

    a_last_row : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_scale_error |-> (o_last_row == (o_row_index == 2'd3)))
        else $error("last row flag off row 3");

endmodule

bind euler_rotation_matrix_generator ermg_props u_ermg_props (.*);
